// File: rtl/ray_box_intersect_top_defines.svh
`ifndef RAY_BOX_INTERSECT_TOP_DEFINES_SVH
`define RAY_BOX_INTERSECT_TOP_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define RBI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RBI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/rbi_pkg.sv
package rbi_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;

	localparam logic [2:0] REG_MIN_X      = 3'd0;
	localparam logic [2:0] REG_MIN_Y      = 3'd1;
	localparam logic [2:0] REG_MIN_Z      = 3'd2;
	localparam logic [2:0] REG_SIZE_X     = 3'd3;
	localparam logic [2:0] REG_SIZE_Y     = 3'd4;
	localparam logic [2:0] REG_SIZE_Z     = 3'd5;
	localparam logic [2:0] REG_REFRACTIVE = 3'd6;

	localparam logic [2:0] FACE_HIGH_X = 3'd3;

	// per-ray control travelling alongside the face results
	typedef struct packed {
		logic       v;
		logic [2:0] dneg;
		logic [2:0] dpos;
	} ray_ctl_t;

endpackage

// File: rtl/rbi_ifs.sv
interface rbi_ray_if #(parameter int CW = rbi_pkg::COORD_WIDTH);
	logic valid;
	logic ready;
	logic signed [CW-1:0] origin_x;
	logic signed [CW-1:0] origin_y;
	logic signed [CW-1:0] origin_z;
	logic signed [CW-1:0] dir_x;
	logic signed [CW-1:0] dir_y;
	logic signed [CW-1:0] dir_z;

	modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		input ready);
	modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		output ready);
endinterface

interface rbi_res_if #(parameter int CW = rbi_pkg::COORD_WIDTH);
	logic valid;
	logic ready;
	logic hit;
	logic [CW-2:0] distance;
	logic [2:0] face;
	logic inside_res;

	modport source (output valid, hit, distance, face, inside_res, input ready);
	modport sink (input valid, hit, distance, face, inside_res, output ready);
endinterface

// File: rtl/rbi_div.sv
module rbi_div #(
	parameter int CW = rbi_pkg::COORD_WIDTH
) (
	input  logic          clk,
	input  logic          en,
	input  logic [CW-1:0] rem_in,
	input  logic [CW-2:0] low_in,
	input  logic [CW-1:0] den_in,
	output logic [CW-2:0] quo
);
	localparam int QW = CW - 1;

	// restoring division, one quotient bit per stage; rem_in must be below den_in
	logic [CW-1:0] rem_s [QW];
	logic [QW-1:0] low_s [QW];
	logic [CW-1:0] den_s [QW];
	logic [QW-1:0] quo_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [CW-1:0] rem_p;
		logic [CW-1:0] den_p;
		logic [QW-1:0] low_p;
		logic [QW-1:0] quo_p;
		logic [CW:0]   trial;
		logic [CW:0]   diff;

		if (k == 0) begin : g_first
			assign rem_p = rem_in;
			assign den_p = den_in;
			assign low_p = low_in;
			assign quo_p = '0;
		end else begin : g_next
			assign rem_p = rem_s[k-1];
			assign den_p = den_s[k-1];
			assign low_p = low_s[k-1];
			assign quo_p = quo_s[k-1];
		end

		assign trial = {rem_p, low_p[QW-1]};
		assign diff  = trial - {1'b0, den_p};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= diff[CW] ? trial[CW-1:0] : diff[CW-1:0];
				low_s[k] <= {low_p[QW-2:0], 1'b0};
				den_s[k] <= den_p;
				quo_s[k] <= {quo_p[QW-2:0], ~diff[CW]};
			end
		end
	end

	assign quo = quo_s[QW-1];
endmodule

// File: rtl/rbi_check.sv
module rbi_check #(
	parameter int CW = rbi_pkg::COORD_WIDTH,
	parameter int FB = rbi_pkg::FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic                 ok_in,
	input  logic [CW-2:0]        t_in,
	input  logic signed [CW-1:0] org [3],
	input  logic signed [CW-1:0] dir [3],
	input  logic signed [CW+1:0] lo_e [3],
	input  logic signed [CW+1:0] hi_e [3],
	output logic                 ok_out,
	output logic [CW-2:0]        t_out
);
	localparam int QW = CW - 1;
	localparam int PW = CW + QW + 1;
	localparam logic signed [PW-1:0] BIAS = {{(PW-FB){1'b0}}, {FB{1'b1}}};

	logic signed [PW-1:0] prod_s1 [3];
	logic signed [CW-1:0] org_s1 [3];
	logic [QW-1:0]        t_s1;
	logic                 ok_s1;

	logic signed [PW-1:0] step_s2 [3];
	logic signed [CW-1:0] org_s2 [3];
	logic [QW-1:0]        t_s2;
	logic                 ok_s2;

	logic signed [PW-1:0] step_c [3];
	logic [2:0]           in_c;

	// hit point offset, truncated toward zero
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			step_c[a] = $signed(prod_s1[a] + (prod_s1[a][PW-1] ? BIAS : '0)) >>> FB;
		end
	end

	always_comb begin
		logic signed [PW-1:0] p;
		for (int a = 0; a < 3; a++) begin
			p = PW'(org_s2[a]) + step_s2[a];
			in_c[a] = (p > PW'(lo_e[a])) && (p < PW'(hi_e[a]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				prod_s1[a] <= dir[a] * $signed({1'b0, t_in});
				org_s1[a]  <= org[a];
				step_s2[a] <= step_c[a];
				org_s2[a]  <= org_s1[a];
			end
			t_s1   <= t_in;
			ok_s1  <= ok_in;
			t_s2   <= t_s1;
			ok_s2  <= ok_s1;
			t_out  <= t_s2;
			ok_out <= ok_s2 && (&in_c);
		end
	end
endmodule

// File: rtl/rbi_select.sv
module rbi_select #(
	parameter int CW = rbi_pkg::COORD_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              refractive,
	input  rbi_pkg::ray_ctl_t ctl,
	input  logic              ok [6],
	input  logic [CW-2:0]     t [6],
	rbi_res_if.source         res
);
	localparam int QW = CW - 1;

	logic              okp_c [3];
	logic [QW-1:0]     tp_c  [3];
	logic [2:0]        fp_c  [3];

	logic              okp_s1 [3];
	logic [QW-1:0]     tp_s1  [3];
	logic [2:0]        fp_s1  [3];
	rbi_pkg::ray_ctl_t ctl_s1;

	logic              hit_c;
	logic [QW-1:0]     t_c;
	logic [2:0]        f_c;
	logic              inside_c;

	// pairwise pick, lower face on equal distance
	for (genvar p = 0; p < 3; p++) begin : g_pair
		logic a_wins;
		assign a_wins  = ok[2*p] && (!ok[2*p+1] || t[2*p] <= t[2*p+1]);
		assign okp_c[p] = ok[2*p] || ok[2*p+1];
		assign tp_c[p]  = a_wins ? t[2*p] : t[2*p+1];
		assign fp_c[p]  = a_wins ? 3'(2*p) : 3'(2*p+1);
	end

	always_comb begin
		logic [1:0] ax;
		logic       leaving;
		hit_c = okp_s1[0];
		t_c   = tp_s1[0];
		f_c   = fp_s1[0];
		for (int p = 1; p < 3; p++) begin
			if (okp_s1[p] && (!hit_c || tp_s1[p] < t_c)) begin
				hit_c = 1'b1;
				t_c   = tp_s1[p];
				f_c   = fp_s1[p];
			end
		end
		ax = (f_c >= rbi_pkg::FACE_HIGH_X) ? 2'(f_c - rbi_pkg::FACE_HIGH_X) : f_c[1:0];
		leaving = 1'b0;
		if (ax != 2'd3) begin
			leaving = (f_c < rbi_pkg::FACE_HIGH_X) ? ctl_s1.dneg[ax] : ctl_s1.dpos[ax];
		end
		inside_c = hit_c && refractive && leaving;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1    <= '0;
			res.valid <= 1'b0;
		end else if (en) begin
			ctl_s1    <= ctl;
			res.valid <= ctl_s1.v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int p = 0; p < 3; p++) begin
				okp_s1[p] <= okp_c[p];
				tp_s1[p]  <= tp_c[p];
				fp_s1[p]  <= fp_c[p];
			end
			res.hit        <= hit_c;
			res.distance   <= hit_c ? t_c : '0;
			res.face       <= hit_c ? f_c : '0;
			res.inside_res <= inside_c;
		end
	end
endmodule

// File: rtl/ray_box_intersect_top.sv
// Ray against axis-aligned box, fully pipelined.
// Box corner, extents and the refractive flag sit in APB registers at byte
// addresses 0x00..0x18 (min x/y/z, size x/y/z, refractive); write them only
// while no ray is in flight. pready is tied high, reads return the register.
// Rays come in on the ray channel (valid/ready), one result per ray leaves on
// the res channel in order: hit, distance (Q15.16), face, inside_res.
// The pipeline has three front stages, one stage per quotient bit in the
// six face dividers, three stages of hit point test and two of nearest-face
// selection. One ray per cycle is accepted when the output is taken every
// cycle. A stalled output holds the whole pipeline: ray.ready follows
// !res.valid || res.ready, so nothing is dropped or repeated.
// Reset clears the box registers to zero and empties the pipeline.
module ray_box_intersect_top #(
	parameter int COORD_WIDTH = rbi_pkg::COORD_WIDTH,
	parameter int FRAC_BITS   = rbi_pkg::FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	rbi_ray_if.sink   ray,
	rbi_res_if.source res,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [((COORD_WIDTH > 32) ? 6 : 5)-1:0] paddr,
	input  logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
	output logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] prdata,
	output logic pready
);
	localparam int CW  = COORD_WIDTH;
	localparam int FB  = FRAC_BITS;
	localparam int QW  = CW - 1;
	localparam int DW  = CW + 2;
	localparam int MW  = CW + 1;
	localparam int NW  = MW + FB;
	localparam int CMW = (NW > CW + QW) ? NW : CW + QW;
	localparam int PDW = (CW > 32) ? 64 : 32;
	localparam int AW  = (CW > 32) ? 6 : 5;
	localparam longint unsigned EPS_U = ((64'd1 << FB) + 64'd500) / 64'd1000;
	localparam logic signed [DW-1:0] EPS_Q = DW'(EPS_U);

	typedef struct packed {
		logic [5:0]           pos;
		logic [5:0]           ovf;
		logic [2:0][CW-1:0]   org;
		logic [2:0][CW-1:0]   dir;
	} side_t;

	logic signed [CW-1:0] box_min_q  [3];
	logic [QW-1:0]        box_size_q [3];
	logic                 refr_q;
	logic [2:0]           reg_idx;

	logic signed [DW-1:0] lo_w [3];
	logic signed [DW-1:0] hi_w [3];
	logic signed [DW-1:0] lo_e [3];
	logic signed [DW-1:0] hi_e [3];
	logic signed [DW-1:0] plane_w [6];
	logic signed [CW-1:0] org_in [3];
	logic signed [CW-1:0] dir_in [3];
	logic signed [CW-1:0] org_f0 [6];
	logic                 en;

	logic                 v_s1;
	logic signed [CW-1:0] org_s1 [3];
	logic signed [CW-1:0] dir_s1 [3];
	logic signed [DW-1:0] diff_s1 [6];
	logic signed [CW-1:0] dirf_s1 [6];

	logic                 v_s2;
	logic signed [CW-1:0] org_s2 [3];
	logic signed [CW-1:0] dir_s2 [3];
	logic [CW-1:0]        dmag_s2 [3];
	logic [MW-1:0]        mag_s2 [6];
	logic                 pos_s2 [6];
	logic [CW-1:0]        dmagf_s2 [6];
	logic [MW-1:0]        mag_c [6];
	logic                 pos_c [6];

	logic                 v_s3;
	logic signed [CW-1:0] org_s3 [3];
	logic signed [CW-1:0] dir_s3 [3];
	logic [CW-1:0]        dmag_s3 [3];
	logic                 pos_s3 [6];
	logic                 ovf_s3 [6];
	logic [CW-1:0]        r0_s3 [6];
	logic [QW-1:0]        low_s3 [6];
	logic [CW-1:0]        denf_s3 [6];
	logic                 ovf_c [6];
	logic [CW-1:0]        r0_c [6];
	logic [QW-1:0]        low_c [6];

	side_t                side_s [QW];
	logic                 vd_s [QW];
	logic [QW-1:0]        quo_d [6];
	logic [QW-1:0]        t_d [6];
	logic                 ok_d [6];
	logic signed [CW-1:0] org_d [3];
	logic signed [CW-1:0] dir_d [3];
	rbi_pkg::ray_ctl_t    ctl_d;

	rbi_pkg::ray_ctl_t    ctl_s [3];
	logic                 ok_c [6];
	logic [QW-1:0]        t_c [6];

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = paddr[AW-1 -: 3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				box_min_q[a]  <= '0;
				box_size_q[a] <= '0;
			end
			refr_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				rbi_pkg::REG_MIN_X:      box_min_q[0]  <= pwdata[CW-1:0];
				rbi_pkg::REG_MIN_Y:      box_min_q[1]  <= pwdata[CW-1:0];
				rbi_pkg::REG_MIN_Z:      box_min_q[2]  <= pwdata[CW-1:0];
				rbi_pkg::REG_SIZE_X:     box_size_q[0] <= pwdata[QW-1:0];
				rbi_pkg::REG_SIZE_Y:     box_size_q[1] <= pwdata[QW-1:0];
				rbi_pkg::REG_SIZE_Z:     box_size_q[2] <= pwdata[QW-1:0];
				rbi_pkg::REG_REFRACTIVE: refr_q        <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			rbi_pkg::REG_MIN_X:      prdata = PDW'(box_min_q[0]);
			rbi_pkg::REG_MIN_Y:      prdata = PDW'(box_min_q[1]);
			rbi_pkg::REG_MIN_Z:      prdata = PDW'(box_min_q[2]);
			rbi_pkg::REG_SIZE_X:     prdata = PDW'(box_size_q[0]);
			rbi_pkg::REG_SIZE_Y:     prdata = PDW'(box_size_q[1]);
			rbi_pkg::REG_SIZE_Z:     prdata = PDW'(box_size_q[2]);
			rbi_pkg::REG_REFRACTIVE: prdata = PDW'(refr_q);
			default:                 prdata = '0;
		endcase
	end

	// box planes, exact width
	for (genvar a = 0; a < 3; a++) begin : g_axis
		assign lo_w[a] = DW'(box_min_q[a]);
		assign hi_w[a] = DW'(box_min_q[a]) + DW'($signed({1'b0, box_size_q[a]}));
		assign lo_e[a] = lo_w[a] - EPS_Q;
		assign hi_e[a] = hi_w[a] + EPS_Q;
		assign org_d[a] = $signed(side_s[QW-1].org[a]);
		assign dir_d[a] = $signed(side_s[QW-1].dir[a]);
		assign ctl_d.dneg[a] = dir_d[a][CW-1];
		assign ctl_d.dpos[a] = !dir_d[a][CW-1] && (dir_d[a] != '0);
	end
	assign ctl_d.v = vd_s[QW-1];

	assign org_in[0] = ray.origin_x;
	assign org_in[1] = ray.origin_y;
	assign org_in[2] = ray.origin_z;
	assign dir_in[0] = ray.dir_x;
	assign dir_in[1] = ray.dir_y;
	assign dir_in[2] = ray.dir_z;

	assign en        = !res.valid || res.ready;
	assign ray.ready = en;

	for (genvar f = 0; f < 6; f++) begin : g_face
		localparam int AX = f % 3;
		logic [NW-1:0]  nmag;
		logic [NW-1:0]  nsh;
		logic [CW+QW-1:0] lim;

		assign plane_w[f]  = (f < 3) ? lo_w[AX] : hi_w[AX];
		assign org_f0[f]   = org_in[AX];
		assign dirf_s1[f]  = dir_s1[AX];
		assign dmagf_s2[f] = dmag_s2[AX];
		assign denf_s3[f]  = dmag_s3[AX];

		// magnitude of plane distance, and whether the quotient is positive
		assign mag_c[f] = diff_s1[f][DW-1] ? MW'(-diff_s1[f]) : MW'(diff_s1[f]);
		assign pos_c[f] = (dirf_s1[f] != '0) && (diff_s1[f] != '0)
			&& (diff_s1[f][DW-1] == dirf_s1[f][CW-1]);

		// quotient beyond the distance range saturates; otherwise it fits QW bits
		assign nmag     = {mag_s2[f], {FB{1'b0}}};
		assign nsh      = nmag >> QW;
		assign lim      = {dmagf_s2[f], {QW{1'b0}}};
		assign ovf_c[f] = CMW'(nmag) >= CMW'(lim);
		assign r0_c[f]  = nsh[CW-1:0];
		assign low_c[f] = nmag[QW-1:0];

		rbi_div #(.CW(CW)) u_div (
			.clk    (clk),
			.en     (en),
			.rem_in (r0_s3[f]),
			.low_in (low_s3[f]),
			.den_in (denf_s3[f]),
			.quo    (quo_d[f])
		);

		assign t_d[f]  = side_s[QW-1].ovf[f] ? '1 : quo_d[f];
		assign ok_d[f] = side_s[QW-1].pos[f] && (t_d[f] != '0);

		rbi_check #(.CW(CW), .FB(FB)) u_check (
			.clk    (clk),
			.en     (en),
			.ok_in  (ok_d[f]),
			.t_in   (t_d[f]),
			.org    (org_d),
			.dir    (dir_d),
			.lo_e   (lo_e),
			.hi_e   (hi_e),
			.ok_out (ok_c[f]),
			.t_out  (t_c[f])
		);
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			for (int k = 0; k < QW; k++) vd_s[k] <= 1'b0;
			for (int k = 0; k < 3; k++) ctl_s[k] <= '0;
		end else if (en) begin
			v_s1 <= ray.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			vd_s[0] <= v_s3;
			for (int k = 1; k < QW; k++) vd_s[k] <= vd_s[k-1];
			ctl_s[0] <= ctl_d;
			for (int k = 1; k < 3; k++) ctl_s[k] <= ctl_s[k-1];
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				org_s1[a]  <= org_in[a];
				dir_s1[a]  <= dir_in[a];
				org_s2[a]  <= org_s1[a];
				dir_s2[a]  <= dir_s1[a];
				dmag_s2[a] <= dir_s1[a][CW-1] ? CW'(-dir_s1[a]) : CW'(dir_s1[a]);
				org_s3[a]  <= org_s2[a];
				dir_s3[a]  <= dir_s2[a];
				dmag_s3[a] <= dmag_s2[a];
				side_s[0].org[a] <= org_s3[a];
				side_s[0].dir[a] <= dir_s3[a];
			end
			for (int f = 0; f < 6; f++) begin
				diff_s1[f] <= plane_w[f] - DW'(org_f0[f]);
				mag_s2[f]  <= mag_c[f];
				pos_s2[f]  <= pos_c[f];
				pos_s3[f]  <= pos_s2[f];
				ovf_s3[f]  <= ovf_c[f];
				r0_s3[f]   <= r0_c[f];
				low_s3[f]  <= low_c[f];
				side_s[0].pos[f] <= pos_s3[f];
				side_s[0].ovf[f] <= ovf_s3[f];
			end
			for (int k = 1; k < QW; k++) side_s[k] <= side_s[k-1];
		end
	end

	rbi_select #(.CW(CW)) u_select (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.refractive (refr_q),
		.ctl        (ctl_s[2]),
		.ok         (ok_c),
		.t          (t_c),
		.res        (res)
	);
endmodule

// File: rtl/rbi_checker.sv
`include "ray_box_intersect_top_defines.svh"

module rbi_checker #(
	parameter int COORD_WIDTH = rbi_pkg::COORD_WIDTH
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic                   hit,
	input logic [COORD_WIDTH-2:0] distance,
	input logic [2:0]             face,
	input logic                   inside_res
);
	`RBI_ASSERT_NOW(a_miss_clear, out_valid && !hit,
		distance == '0 && face == 3'd0 && !inside_res, "miss carries nonzero fields")
	`RBI_ASSERT_NOW(a_face_range, out_valid && hit, face <= 3'd5, "face index out of range")
	`RBI_ASSERT_NOW(a_inside_hit, out_valid && inside_res, hit, "inside flag without hit")
	`RBI_ASSERT_NOW(a_ready_free, in_valid || !in_valid, in_ready == (!out_valid || out_ready),
		"input ready does not follow output slot")
	`RBI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(distance) && $stable(face), "stalled result changed")
endmodule

bind ray_box_intersect_top rbi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rbi_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (ray.valid),
	.in_ready   (ray.ready),
	.out_valid  (res.valid),
	.out_ready  (res.ready),
	.hit        (res.hit),
	.distance   (res.distance),
	.face       (res.face),
	.inside_res (res.inside_res)
);
